### hdl/assert_macros.svh
// assertion helpers for the checker in drm_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define DRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define DRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/drm_pkg.sv
// ----------------------------------------------------------------------------
// drm_pkg
// Types and constants of the dirty rectangle merger.
// ----------------------------------------------------------------------------
`default_nettype none

package drm_pkg;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_MARK  = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    localparam logic [1:0] OUTC_NONE     = 2'd0;
    localparam logic [1:0] OUTC_MERGED   = 2'd1;
    localparam logic [1:0] OUTC_APPENDED = 2'd2;

    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_JOIN_SLACK    = 2'd2;

    localparam logic [9:0]  SCREEN_WIDTH_RST  = 10'd320;
    localparam logic [9:0]  SCREEN_HEIGHT_RST = 10'd240;
    localparam logic [19:0] JOIN_SLACK_RST    = 20'd380;

    localparam logic [23:0] AREA_MAX = 24'hFFFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLAMP,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [9:0]  screen_width;
        logic [9:0]  screen_height;
        logic [19:0] join_slack;
    } cfg_t;

    typedef struct packed {
        logic [9:0] left;
        logic [9:0] top;
        logic [9:0] right;
        logic [9:0] bottom;
    } rect_t;

    typedef struct packed {
        logic [1:0]  add_outcome;
        logic        entry_valid;
        rect_t       entry;
        logic [5:0]  entry_count;
        logic        whole_screen;
        logic [23:0] total_area;
    } res_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic clamp;
        logic scan;
        logic decide;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic add_ok;
        logic cnt_zero;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

### hdl/drm_if.sv
// ----------------------------------------------------------------------------
// drm_in_if / drm_out_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface drm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [11:0] rect_x;
    logic signed [11:0] rect_y;
    logic signed [11:0] rect_w;
    logic signed [11:0] rect_h;
    logic [4:0]         entry_index;

    modport source (output valid, action, rect_x, rect_y, rect_w, rect_h, entry_index,
                    input ready);
    modport sink   (input valid, action, rect_x, rect_y, rect_w, rect_h, entry_index,
                    output ready);
endinterface

interface drm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  add_outcome;
    logic        entry_valid;
    logic [9:0]  entry_left;
    logic [9:0]  entry_top;
    logic [9:0]  entry_right;
    logic [9:0]  entry_bottom;
    logic [5:0]  entry_count;
    logic        whole_screen;
    logic [23:0] total_area;

    modport source (output valid, add_outcome, entry_valid, entry_left, entry_top,
                    entry_right, entry_bottom, entry_count, whole_screen, total_area,
                    input ready);
    modport sink   (input valid, add_outcome, entry_valid, entry_left, entry_top,
                    entry_right, entry_bottom, entry_count, whole_screen, total_area,
                    output ready);
endinterface

`default_nettype wire

### hdl/drm_cfg.sv
// ----------------------------------------------------------------------------
// drm_cfg
// APB register file: screen width, screen height and join slack.
// ----------------------------------------------------------------------------
`default_nettype none

module drm_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output drm_pkg::cfg_t     cfg
);
    import drm_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= SCREEN_WIDTH_RST;
            cfg_reg.screen_height <= SCREEN_HEIGHT_RST;
            cfg_reg.join_slack    <= JOIN_SLACK_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= pwdata[9:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= pwdata[9:0];
                REG_JOIN_SLACK:    cfg_reg.join_slack    <= pwdata[19:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SCREEN_WIDTH:  prdata = 32'(cfg_reg.screen_width);
            REG_SCREEN_HEIGHT: prdata = 32'(cfg_reg.screen_height);
            REG_JOIN_SLACK:    prdata = 32'(cfg_reg.join_slack);
            default:           prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

### hdl/drm_ctrl.sv
// ----------------------------------------------------------------------------
// drm_ctrl
// Sequencer: accept, run clear, mark or read, or clamp, scan table, merge or append; publish result.
// ----------------------------------------------------------------------------
`default_nettype none

module drm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic [1:0]        req_action,
    output logic                   req_ready,
    input  wire drm_pkg::status_t  st,
    output drm_pkg::cmd_t          cmd
);
    import drm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (action_t'(req_action) == ACT_ADD) ? ST_CLAMP : ST_EXEC;
                end
            end
            ST_EXEC:   state_next = ST_FINISH;
            ST_CLAMP:
            begin
                if (!st.add_ok)
                begin
                    state_next = ST_FINISH;
                end
                else if (st.cnt_zero)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (st.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:   cmd.load    = accept;
            ST_EXEC:   cmd.exec    = 1'b1;
            ST_CLAMP:  cmd.clamp   = 1'b1;
            ST_SCAN:   cmd.scan    = 1'b1;
            ST_DRAIN:  cmd         = '0;
            ST_DECIDE: cmd.decide  = 1'b1;
            ST_FINISH: cmd.publish = st.out_free;
            default:   cmd         = '0;
        endcase
    end

endmodule

`default_nettype wire

### hdl/drm_dp.sv
// ----------------------------------------------------------------------------
// drm_dp
// Datapath: rectangle table, clamp, two-stage waste scan, area tally and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module drm_dp #(
    parameter int MAX_ENTRIES = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire drm_pkg::cfg_t      cfg,
    input  wire drm_pkg::cmd_t      cmd,
    output drm_pkg::status_t        st,
    input  wire logic [1:0]         req_action,
    input  wire logic signed [11:0] req_x,
    input  wire logic signed [11:0] req_y,
    input  wire logic signed [11:0] req_w,
    input  wire logic signed [11:0] req_h,
    input  wire logic [4:0]         req_index,
    output drm_pkg::res_t           res,
    output logic                    res_valid,
    input  wire logic               res_ready
);
    import drm_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = 20 + CW;

    // captured request
    action_t            act_reg;
    logic signed [11:0] x_reg, y_reg, w_reg, h_reg;
    logic [4:0]         idx_reg;

    // table state
    rect_t              tab_reg  [MAX_ENTRIES];
    logic [19:0]        area_reg [MAX_ENTRIES];
    logic [CW-1:0]      count_reg;
    logic               all_reg;
    logic [SW-1:0]      sum_reg;
    logic [1:0]         outc_reg;

    // clamped rectangle
    rect_t              nb_reg;
    logic [19:0]        nb_area_reg;

    // scan pipeline
    logic [IW-1:0]      scan_idx_reg;
    logic               p1_valid_reg;
    logic               p1_first_reg;
    logic [19:0]        p1_ua_reg;
    logic [19:0]        p1_ea_reg;
    rect_t              p1_un_reg;
    logic [IW-1:0]      p1_idx_reg;

    logic signed [21:0] low_waste_reg;
    logic [19:0]        best_ua_reg;
    logic [19:0]        best_ea_reg;
    rect_t              best_un_reg;
    logic [IW-1:0]      best_idx_reg;

    res_t               res_reg;
    logic               res_valid_reg;

    // clamp
    logic signed [12:0] x13, y13, w13, h13, xe13, ye13;
    logic signed [12:0] l13, t13, r13, b13, sw13, sh13;
    logic               clamp_ok;
    logic [9:0]         nb_w, nb_h;
    logic [19:0]        nb_area_c;
    rect_t              nb_c;

    always_comb
    begin
        x13  = {x_reg[11], x_reg};
        y13  = {y_reg[11], y_reg};
        w13  = {w_reg[11], w_reg};
        h13  = {h_reg[11], h_reg};
        xe13 = x13 + w13;
        ye13 = y13 + h13;
        sw13 = $signed({3'b000, cfg.screen_width});
        sh13 = $signed({3'b000, cfg.screen_height});
        l13  = x13[12] ? 13'sd0 : x13;
        t13  = y13[12] ? 13'sd0 : y13;
        r13  = (xe13 > sw13) ? sw13 : xe13;
        b13  = (ye13 > sh13) ? sh13 : ye13;
        clamp_ok = (w13 > 13'sd0) && (h13 > 13'sd0) && (r13 > l13) && (b13 > t13);
        nb_w = 10'(r13 - l13);
        nb_h = 10'(b13 - t13);
        nb_c.left   = l13[9:0];
        nb_c.top    = t13[9:0];
        nb_c.right  = r13[9:0];
        nb_c.bottom = b13[9:0];
    end

    assign nb_area_c = 20'(nb_w) * 20'(nb_h);

    // single table read port, scan index or read index
    logic [IW-1:0] rd_addr;
    rect_t         rd_ent;
    rect_t         un_c;
    logic [9:0]    un_w, un_h;
    logic [19:0]   ua_c;

    assign rd_addr = cmd.scan ? scan_idx_reg : idx_reg[IW-1:0];
    assign rd_ent  = tab_reg[rd_addr];

    always_comb
    begin
        un_c.left   = (rd_ent.left   < nb_reg.left)   ? rd_ent.left   : nb_reg.left;
        un_c.top    = (rd_ent.top    < nb_reg.top)    ? rd_ent.top    : nb_reg.top;
        un_c.right  = (rd_ent.right  > nb_reg.right)  ? rd_ent.right  : nb_reg.right;
        un_c.bottom = (rd_ent.bottom > nb_reg.bottom) ? rd_ent.bottom : nb_reg.bottom;
        un_w = un_c.right - un_c.left;
        un_h = un_c.bottom - un_c.top;
    end

    assign ua_c = 20'(un_w) * 20'(un_h);

    // waste of the entry in stage one; union minus both areas, may go negative
    logic signed [21:0] waste_c;
    assign waste_c = $signed({2'b00, p1_ua_reg}) - $signed({2'b00, p1_ea_reg})
                   - $signed({2'b00, nb_area_reg});

    // merge or append
    logic full_c, merge_c;
    assign full_c  = (count_reg == CW'(MAX_ENTRIES));
    assign merge_c = (count_reg != '0)
                   && ((low_waste_reg <= $signed({2'b00, cfg.join_slack})) || full_c);

    // result
    logic          rd_ok;
    logic [23:0]   sum_sat;
    logic [19:0]   screen_area;
    res_t          res_c;

    assign rd_ok       = (act_reg == ACT_READ) && (6'(idx_reg) < 6'(count_reg));
    assign sum_sat     = (26'(sum_reg) > 26'(AREA_MAX)) ? AREA_MAX : 24'(sum_reg);
    assign screen_area = 20'(cfg.screen_width) * 20'(cfg.screen_height);

    always_comb
    begin
        res_c.add_outcome  = outc_reg;
        res_c.entry_valid  = rd_ok;
        res_c.entry        = rd_ok ? rd_ent : '0;
        res_c.entry_count  = 6'(count_reg);
        res_c.whole_screen = all_reg;
        res_c.total_area   = all_reg ? 24'(screen_area) : sum_sat;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            all_reg       <= 1'b0;
            sum_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cmd.scan;
            if (cmd.exec && (act_reg == ACT_CLEAR || act_reg == ACT_MARK))
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                all_reg   <= (act_reg == ACT_MARK);
            end
            if (cmd.decide)
            begin
                if (merge_c)
                begin
                    sum_reg <= sum_reg - SW'(best_ea_reg) + SW'(best_ua_reg);
                end
                else if (!full_c)
                begin
                    sum_reg   <= sum_reg + SW'(nb_area_reg);
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (cmd.publish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg      <= action_t'(req_action);
            x_reg        <= req_x;
            y_reg        <= req_y;
            w_reg        <= req_w;
            h_reg        <= req_h;
            idx_reg      <= req_index;
            outc_reg     <= OUTC_NONE;
            scan_idx_reg <= '0;
        end
        if (cmd.clamp)
        begin
            nb_reg      <= nb_c;
            nb_area_reg <= nb_area_c;
        end
        if (cmd.scan)
        begin
            scan_idx_reg <= scan_idx_reg + IW'(1);
            p1_first_reg <= (scan_idx_reg == '0);
            p1_ua_reg    <= ua_c;
            p1_ea_reg    <= area_reg[scan_idx_reg];
            p1_un_reg    <= un_c;
            p1_idx_reg   <= scan_idx_reg;
        end
        // strict compare keeps the lowest index on a tie
        if (p1_valid_reg && (p1_first_reg || waste_c < low_waste_reg))
        begin
            low_waste_reg <= waste_c;
            best_ua_reg   <= p1_ua_reg;
            best_ea_reg   <= p1_ea_reg;
            best_un_reg   <= p1_un_reg;
            best_idx_reg  <= p1_idx_reg;
        end
        if (cmd.decide)
        begin
            if (merge_c)
            begin
                tab_reg[best_idx_reg]  <= best_un_reg;
                area_reg[best_idx_reg] <= best_ua_reg;
                outc_reg               <= OUTC_MERGED;
            end
            else if (!full_c)
            begin
                tab_reg[count_reg[IW-1:0]]  <= nb_reg;
                area_reg[count_reg[IW-1:0]] <= nb_area_reg;
                outc_reg                    <= OUTC_APPENDED;
            end
        end
        if (cmd.publish)
        begin
            res_reg <= res_c;
        end
    end

    assign st.add_ok    = clamp_ok && !all_reg;
    assign st.cnt_zero  = (count_reg == '0);
    assign st.scan_last = ((CW'(scan_idx_reg) + CW'(1)) == count_reg);
    assign st.out_free  = !res_valid_reg || res_ready;

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

### hdl/dirty_rectangle_merger_top.sv
// ----------------------------------------------------------------------------
// dirty_rectangle_merger_top
// Dirty rectangle table with clamp, cheapest-merge search and area tally.
// ----------------------------------------------------------------------------
//   channel  dir  handshake           carries
//   req      in   valid/ready         action, rectangle, entry index
//   rsp      out  valid/ready         outcome, read entry, count, area
//   apb      in   psel/penable/pready screen width, screen height, join slack
//
// one request at a time; clear, mark and read run an exec step, then publish;
// an add runs clamp, waste scan, drain, decide and publish (dropped adds go
// from clamp to publish, adds into an empty table skip scan and drain); the
// scan takes one entry per cycle through a shared union-area multiplier
// the result sits in an output register, so the next request is taken while
// a result waits; a stalled rsp holds only the final publish step
// rst_n clears the table count, whole-screen flag, area tally and config
// ----------------------------------------------------------------------------
`default_nettype none

module dirty_rectangle_merger_top #(
    parameter int MAX_ENTRIES = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    drm_in_if.sink            req,
    drm_out_if.source         rsp,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import drm_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t st;
    res_t    res;

    drm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    drm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .req_ready  (req.ready),
        .st         (st),
        .cmd        (cmd)
    );

    drm_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .st         (st),
        .req_action (req.action),
        .req_x      (req.rect_x),
        .req_y      (req.rect_y),
        .req_w      (req.rect_w),
        .req_h      (req.rect_h),
        .req_index  (req.entry_index),
        .res        (res),
        .res_valid  (rsp.valid),
        .res_ready  (rsp.ready)
    );

    assign rsp.add_outcome  = res.add_outcome;
    assign rsp.entry_valid  = res.entry_valid;
    assign rsp.entry_left   = res.entry.left;
    assign rsp.entry_top    = res.entry.top;
    assign rsp.entry_right  = res.entry.right;
    assign rsp.entry_bottom = res.entry.bottom;
    assign rsp.entry_count  = res.entry_count;
    assign rsp.whole_screen = res.whole_screen;
    assign rsp.total_area   = res.total_area;

endmodule

`default_nettype wire

### hdl/drm_checker.sv
// ----------------------------------------------------------------------------
// drm_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module drm_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rsp_valid,
    input  wire logic        rsp_ready,
    input  wire logic [1:0]  add_outcome,
    input  wire logic        entry_valid,
    input  wire logic [9:0]  entry_left,
    input  wire logic [9:0]  entry_top,
    input  wire logic [9:0]  entry_right,
    input  wire logic [9:0]  entry_bottom,
    input  wire logic [5:0]  entry_count,
    input  wire logic        whole_screen,
    input  wire logic [23:0] total_area
);
    import drm_pkg::*;

    // a stalled beat keeps its contents
    `DRM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(add_outcome) && $stable(entry_count) && $stable(total_area),
        "result beat changed while stalled")

    // whole screen marked leaves the table empty and no add can land
    `DRM_ASSERT_NOW(a_whole_empty, rsp_valid && whole_screen,
        entry_count == 6'd0 && add_outcome == OUTC_NONE && !entry_valid,
        "whole screen with table entries or add outcome")

    // a merge or append leaves at least one entry
    `DRM_ASSERT_NOW(a_add_count, rsp_valid && add_outcome != OUTC_NONE,
        entry_count != 6'd0 && !whole_screen
        && (add_outcome == OUTC_MERGED || add_outcome == OUTC_APPENDED),
        "add outcome with empty table")

    // stored rectangles are never empty
    `DRM_ASSERT_NOW(a_entry_shape, rsp_valid && entry_valid,
        entry_right > entry_left && entry_bottom > entry_top,
        "read entry is empty")

    // empty table without whole-screen mark has no area
    `DRM_ASSERT_NOW(a_empty_area, rsp_valid && !whole_screen && entry_count == 6'd0,
        total_area == 24'd0,
        "area reported for empty table")

endmodule

bind dirty_rectangle_merger_top drm_checker u_drm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .add_outcome  (rsp.add_outcome),
    .entry_valid  (rsp.entry_valid),
    .entry_left   (rsp.entry_left),
    .entry_top    (rsp.entry_top),
    .entry_right  (rsp.entry_right),
    .entry_bottom (rsp.entry_bottom),
    .entry_count  (rsp.entry_count),
    .whole_screen (rsp.whole_screen),
    .total_area   (rsp.total_area)
);

`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dirty_rectangle_merger_top. Sends request beats over
// the req channel, programs the screen size and join slack over APB between
// phases, keeps a shadow copy of the rectangle table to work out each result,
// and checks every rsp beat field by field against the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import drm_pkg::*;

    localparam int TABLE_DEPTH   = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;

    typedef struct {
        action_t            action;
        logic signed [11:0] rect_x;
        logic signed [11:0] rect_y;
        logic signed [11:0] rect_w;
        logic signed [11:0] rect_h;
        logic [4:0]         entry_index;
    } request_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    drm_in_if  req_ch ();
    drm_out_if rsp_ch ();

    // shadow of the block state
    cfg_t  shadow_cfg;
    rect_t dirty_table [TABLE_DEPTH];
    int    dirty_count;
    bit    screen_marked;

    res_t  pending_results [$];
    res_t  due;
    int    mismatch_count = 0;
    int    cycle_count    = 0;
    int    rsp_stall_left = 0;
    bit    idle_on;
    bit    rsp_hold;

    dirty_rectangle_merger_top #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** dirty_rectangle_merger_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // table predictor
    // ------------------------------------------------------------------------
    function automatic longint rect_pixels(rect_t e);
        int w;
        int h;
        w = int'(e.right) - int'(e.left);
        h = int'(e.bottom) - int'(e.top);
        return longint'(w) * longint'(h);
    endfunction

    // area of the bounding union minus the areas of both rectangles (may go negative on overlap)
    function automatic longint union_waste(rect_t a, rect_t b);
        int l;
        int t;
        int r;
        int d;
        l = (a.left < b.left) ? int'(a.left) : int'(b.left);
        t = (a.top < b.top) ? int'(a.top) : int'(b.top);
        r = (a.right > b.right) ? int'(a.right) : int'(b.right);
        d = (a.bottom > b.bottom) ? int'(a.bottom) : int'(b.bottom);
        return longint'(r - l) * longint'(d - t) - rect_pixels(a) - rect_pixels(b);
    endfunction

    function automatic logic [1:0] add_rectangle(request_t rq);
        int     x0;
        int     y0;
        int     w;
        int     h;
        int     sw;
        int     sh;
        int     left;
        int     top;
        int     right;
        int     bottom;
        int     best;
        longint low_waste;
        longint cost;
        longint slack;
        rect_t  nb;
        x0 = int'(rq.rect_x);
        y0 = int'(rq.rect_y);
        w  = int'(rq.rect_w);
        h  = int'(rq.rect_h);
        sw = int'(shadow_cfg.screen_width);
        sh = int'(shadow_cfg.screen_height);
        slack = longint'(shadow_cfg.join_slack);
        if (screen_marked || w <= 0 || h <= 0)
            return OUTC_NONE;
        left   = (x0 < 0) ? 0 : x0;
        top    = (y0 < 0) ? 0 : y0;
        right  = (x0 + w > sw) ? sw : x0 + w;
        bottom = (y0 + h > sh) ? sh : y0 + h;
        if (right <= left || bottom <= top)
            return OUTC_NONE;
        nb.left   = left[9:0];
        nb.top    = top[9:0];
        nb.right  = right[9:0];
        nb.bottom = bottom[9:0];

        best = -1;
        low_waste = 0;
        for (int i = 0; i < dirty_count; i++)
        begin
            cost = union_waste(dirty_table[i], nb);
            if (best < 0 || cost < low_waste)
            begin
                best = i;
                low_waste = cost;
            end
        end
        if (best >= 0 && (low_waste <= slack || dirty_count >= TABLE_DEPTH))
        begin
            if (nb.left < dirty_table[best].left)
                dirty_table[best].left = nb.left;
            if (nb.top < dirty_table[best].top)
                dirty_table[best].top = nb.top;
            if (nb.right > dirty_table[best].right)
                dirty_table[best].right = nb.right;
            if (nb.bottom > dirty_table[best].bottom)
                dirty_table[best].bottom = nb.bottom;
            return OUTC_MERGED;
        end
        if (dirty_count >= TABLE_DEPTH)
            return OUTC_NONE;
        dirty_table[dirty_count] = nb;
        dirty_count++;
        return OUTC_APPENDED;
    endfunction

    function automatic res_t apply_request(request_t rq);
        res_t   r;
        longint sum;
        int     sw;
        int     sh;
        r = '0;
        case (rq.action)
            ACT_ADD:
                r.add_outcome = add_rectangle(rq);
            ACT_CLEAR:
            begin
                dirty_count = 0;
                screen_marked = 1'b0;
            end
            ACT_MARK:
            begin
                dirty_count = 0;
                screen_marked = 1'b1;
            end
            default:
                if (int'(rq.entry_index) < dirty_count)
                begin
                    r.entry_valid = 1'b1;
                    r.entry = dirty_table[int'(rq.entry_index)];
                end
        endcase
        sw = int'(shadow_cfg.screen_width);
        sh = int'(shadow_cfg.screen_height);
        sum = 0;
        if (screen_marked)
            sum = longint'(sw) * longint'(sh);
        else
            for (int i = 0; i < dirty_count; i++)
                sum += rect_pixels(dirty_table[i]);
        if (sum > 16777215)
            r.total_area = AREA_MAX;
        else
            r.total_area = sum[23:0];
        r.entry_count  = dirty_count[5:0];
        r.whole_screen = screen_marked;
        return r;
    endfunction

    // adds of mostly well-formed rectangles near the current screen, some raw noise, plus reads, clears and marks
    function automatic request_t next_random_request();
        request_t rq;
        int       pick;
        int       sw;
        int       sh;
        sw = int'(shadow_cfg.screen_width);
        sh = int'(shadow_cfg.screen_height);
        rq.rect_x = 12'($urandom_range(0, 4095));
        rq.rect_y = 12'($urandom_range(0, 4095));
        rq.rect_w = 12'($urandom_range(0, 4095));
        rq.rect_h = 12'($urandom_range(0, 4095));
        rq.entry_index = 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 62)
        begin
            rq.action = ACT_ADD;
            if ($urandom_range(0, 9) != 0)
            begin
                rq.rect_x = 12'(int'($urandom_range(0, sw + 16)) - 8);
                rq.rect_y = 12'(int'($urandom_range(0, sh + 16)) - 8);
                rq.rect_w = 12'($urandom_range(1, sw / 3 + 2));
                rq.rect_h = 12'($urandom_range(1, sh / 3 + 2));
            end
        end
        else if (pick < 87)
        begin
            rq.action = ACT_READ;
            if ($urandom_range(0, 3) != 0)
                rq.entry_index = 5'($urandom_range(0, dirty_count));
        end
        else if (pick < 95)
            rq.action = ACT_CLEAR;
        else
            rq.action = ACT_MARK;
        return rq;
    endfunction

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rsp_hold)
            rsp_ch.ready <= 1'b0;
        else if (rsp_stall_left > 0)
        begin
            rsp_stall_left <= rsp_stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            rsp_stall_left <= $urandom_range(0, 10);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat expected none, got count %0d area %0d",
                         $time, rsp_ch.entry_count, rsp_ch.total_area);
                mismatch_count++;
            end
            else
            begin
                due = pending_results.pop_front();
                compare_field("add_outcome", 32'(due.add_outcome), 32'(rsp_ch.add_outcome));
                compare_field("entry_valid", 32'(due.entry_valid), 32'(rsp_ch.entry_valid));
                compare_field("entry_left", 32'(due.entry.left), 32'(rsp_ch.entry_left));
                compare_field("entry_top", 32'(due.entry.top), 32'(rsp_ch.entry_top));
                compare_field("entry_right", 32'(due.entry.right), 32'(rsp_ch.entry_right));
                compare_field("entry_bottom", 32'(due.entry.bottom),
                              32'(rsp_ch.entry_bottom));
                compare_field("entry_count", 32'(due.entry_count), 32'(rsp_ch.entry_count));
                compare_field("whole_screen", 32'(due.whole_screen),
                              32'(rsp_ch.whole_screen));
                compare_field("total_area", 32'(due.total_area), 32'(rsp_ch.total_area));
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    task automatic send_item(request_t rq);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            repeat (gap)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
            end
        end
        @(negedge clk);
        req_ch.valid       <= 1'b1;
        req_ch.action      <= rq.action;
        req_ch.rect_x      <= rq.rect_x;
        req_ch.rect_y      <= rq.rect_y;
        req_ch.rect_w      <= rq.rect_w;
        req_ch.rect_h      <= rq.rect_h;
        req_ch.entry_index <= rq.entry_index;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        pending_results.push_back(apply_request(rq));
    endtask

    task automatic send_req(action_t act, int x, int y, int w, int h, int index);
        request_t rq;
        rq.action      = act;
        rq.rect_x      = 12'(x);
        rq.rect_y      = 12'(y);
        rq.rect_w      = 12'(w);
        rq.rect_h      = 12'(h);
        rq.entry_index = 5'(index);
        send_item(rq);
    endtask

    task automatic run_random(int count);
        repeat (count)
            send_item(next_random_request());
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_SCREEN_WIDTH:  shadow_cfg.screen_width  = value[9:0];
            REG_SCREEN_HEIGHT: shadow_cfg.screen_height = value[9:0];
            REG_JOIN_SLACK:    shadow_cfg.join_slack    = value[19:0];
            default: ;
        endcase
    endtask

    // table is kept across the change; existing entries keep their edges
    task automatic change_screen(int w, int h, int slack);
        wait_drained();
        write_register(REG_SCREEN_WIDTH, w);
        write_register(REG_SCREEN_HEIGHT, h);
        write_register(REG_JOIN_SLACK, slack);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_cases();
        int i;
        idle_on = 1'b1;
        send_req(ACT_READ, 0, 0, 0, 0, 0);
        send_req(ACT_ADD, 10, 10, 0, 20, 0);
        send_req(ACT_ADD, 10, 10, 20, -5, 0);
        // both of these clamp down to nothing
        send_req(ACT_ADD, -2048, -2048, 2047, 2047, 0);
        send_req(ACT_ADD, 2047, 2047, 2047, 2047, 0);
        send_req(ACT_ADD, -10, -10, 100, 50, 31);
        send_req(ACT_ADD, 300, 200, 2047, 2047, 0);
        send_req(ACT_ADD, 85, 0, 10, 40, 0);
        send_req(ACT_READ, 0, 0, 0, 0, 0);
        send_req(ACT_READ, 0, 0, 0, 0, 1);
        send_req(ACT_READ, 0, 0, 0, 0, 31);
        send_req(ACT_MARK, 0, 0, 0, 0, 0);
        send_req(ACT_ADD, 20, 20, 30, 30, 0);
        send_req(ACT_READ, 0, 0, 0, 0, 0);
        send_req(ACT_CLEAR, 0, 0, 0, 0, 0);
        // far-apart squares fill the table, the ninth is forced to merge
        for (i = 0; i < 9; i++)
            send_req(ACT_ADD, i * 38, (i % 2) * 200, 10, 10, i);
        send_req(ACT_READ, 0, 0, 0, 0, 7);
    endtask

    task automatic test_random_traffic();
        idle_on = 1'b1;
        run_random(300);
    endtask

    task automatic test_screen_settings();
        idle_on = 1'b1;
        change_screen(1, 1, 0);
        run_random(70);
        change_screen(1023, 1023, 1048575);
        run_random(70);
        change_screen(1023, 1, 0);
        run_random(70);
        change_screen(1, 1023, 1048575);
        run_random(70);
        change_screen($urandom_range(1, 1023), $urandom_range(1, 1023),
                      $urandom_range(0, 1048575));
        run_random(70);
        change_screen(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, JOIN_SLACK_RST);
        run_random(70);
    endtask

    task automatic test_output_backpressure();
        idle_on = 1'b1;
        fork
            begin
                rsp_hold = 1'b1;
                repeat (300) @(posedge clk);
                rsp_hold = 1'b0;
            end
        join_none
        run_random(40);
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        run_random(320);
    endtask

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_ADD;
        req_ch.rect_x      = '0;
        req_ch.rect_y      = '0;
        req_ch.rect_w      = '0;
        req_ch.rect_h      = '0;
        req_ch.entry_index = '0;
        rsp_ch.ready       = 1'b0;
        shadow_cfg.screen_width  = SCREEN_WIDTH_RST;
        shadow_cfg.screen_height = SCREEN_HEIGHT_RST;
        shadow_cfg.join_slack    = JOIN_SLACK_RST;
        dirty_count   = 0;
        screen_marked = 1'b0;
        idle_on       = 1'b1;
        rsp_hold      = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_screen_settings();
        test_output_backpressure();
        test_steady_stream();
        wait_drained();

        if (mismatch_count == 0)
            $display("** dirty_rectangle_merger_top: PASSED **");
        else
            $display("** dirty_rectangle_merger_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
